// File: hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the work-stealing deque: command and status
// codes, field widths and the request / response payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 64;
    localparam int COUNT_W       = 5;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_STEAL = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [WORD_W-1:0] work_word;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [WORD_W-1:0]  taken_word;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    // outcome of one operation, carried alongside the slot read
    typedef struct packed {
        logic [1:0]         status;
        logic               take;
        logic [COUNT_W-1:0] count;
    } op_res_t;

endpackage : wsd_pkg

`default_nettype wire

// File: hw/rtl/work_stealing_deque.sv
// ----------------------------------------------------------------------------
// work_stealing_deque
// Fixed-capacity ring deque of 64-bit work words: push and pop at the
// bottom, steal from the top, one result per request.
//
//   channel | signals                          | payload
//   --------+----------------------------------+--------------------------
//   req     | req_valid / req_ready / req      | cmd, work_word
//   rsp     | rsp_valid / rsp_ready / rsp      | status, taken_word, count
//
// one request per cycle sustained while rsp takes every result; the slot read
// for a request lands at its transfer edge, and the output register loads the
// result when the output stage is free, so a stall on rsp can come between.
// the single-port slot memory takes one access per request, so requests
// never collide on it; a pop right after a push reads the written word.
// reset clears the indices, count and valid flags; slot contents stay as they are.
// a stall on rsp holds both stages, and req_ready drops once they are full.
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_deque
    import wsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int AW = $clog2(DEPTH);

    logic              req_xfer;
    logic              wr_en, rd_en;
    logic [AW-1:0]     addr;
    logic [WORD_W-1:0] wr_data, rd_data;
    op_res_t           res;

    logic              s1_valid_reg, s1_valid_next;
    op_res_t           s1_res_reg;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_reg, out_next;
    logic              out_free, s1_adv;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign req_xfer  = req_valid && req_ready;

    wsd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .xfer    (req_xfer),
        .req     (req),
        .wr_en   (wr_en),
        .rd_en   (rd_en),
        .addr    (addr),
        .wr_data (wr_data),
        .res     (res)
    );

    wsd_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .rd_en   (rd_en),
        .addr    (addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (s1_adv)
        begin
            out_valid_next      = 1'b1;
            out_next.status     = s1_res_reg.status;
            out_next.taken_word = s1_res_reg.take ? rd_data : '0;
            out_next.count      = s1_res_reg.count;
            s1_valid_next       = 1'b0;
        end
        else if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (req_xfer)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_res_reg <= res;
        end
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule : work_stealing_deque

`default_nettype wire

// File: hw/rtl/wsd_mem.sv
// ----------------------------------------------------------------------------
// wsd_mem
// Slot storage: single-port synchronous memory, one access per cycle,
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_mem
    import wsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     addr,
    input  wire logic [WORD_W-1:0] wr_data,
    output logic      [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : wsd_mem

`default_nettype wire

// File: hw/rtl/wsd_ctrl.sv
// ----------------------------------------------------------------------------
// wsd_ctrl
// Index and count bookkeeping: decodes a command, checks full / empty / null,
// drives the slot memory access and moves the top and bottom slots.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_ctrl
    import wsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              xfer,
    input  wire req_t              req,
    output logic                   wr_en,
    output logic                   rd_en,
    output logic      [AW-1:0]     addr,
    output logic      [WORD_W-1:0] wr_data,
    output op_res_t                res
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [AW-1:0] top_reg, top_next;
    logic [AW-1:0] bot_reg, bot_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [AW-1:0] bot_inc, bot_dec, top_inc;
    logic          is_empty, is_full;

    assign bot_inc  = (bot_reg == LAST_SLOT) ? '0 : bot_reg + AW'(1);
    assign bot_dec  = (bot_reg == '0) ? LAST_SLOT : bot_reg - AW'(1);
    assign top_inc  = (top_reg == LAST_SLOT) ? '0 : top_reg + AW'(1);
    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == FULL_CNT);

    always_comb
    begin
        top_next   = top_reg;
        bot_next   = bot_reg;
        cnt_next   = cnt_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        addr       = bot_reg;
        wr_data    = req.work_word;
        res.status = ST_DONE;
        res.take   = 1'b0;
        unique case (req.cmd)
            CMD_PUSH:
            begin
                if (req.work_word == '0)
                begin
                    res.status = ST_NULL;
                end
                else if (is_full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    wr_en    = xfer;
                    bot_next = bot_inc;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            CMD_POP:
            begin
                addr = bot_dec;
                if (is_empty)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    rd_en    = xfer;
                    res.take = 1'b1;
                    bot_next = bot_dec;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            CMD_STEAL:
            begin
                addr = top_reg;
                if (is_empty)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    rd_en    = xfer;
                    res.take = 1'b1;
                    top_next = top_inc;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            default:
            begin
                // unknown command: no operation, report current count
            end
        endcase
        res.count = COUNT_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            bot_reg <= '0;
            cnt_reg <= '0;
        end
        else if (xfer)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule : wsd_ctrl

`default_nettype wire

// File: sim/work_stealing_deque_tb.sv
// ----------------------------------------------------------------------------
// work_stealing_deque_tb
// Self-checking testbench for the work-stealing deque. A short table of directed
// requests (empty and full deque, null items, extreme words, the unused command)
// is followed by random request bursts that swing the deque between full and
// empty. Every response is compared field by field with the table's entry for
// fixed rows or else a behavioral deque model kept in the testbench, with random
// idling on both channels and one long response stall that backs up requests.
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_deque_tb;
    import wsd_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int RAND_ITEMS = 1750;
    localparam int IDLE_PCT = 17;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 10;
    localparam int REPORT_MAX = 10;
    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
    localparam logic [WORD_W-1:0] TOP_BIT = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        req_t op;
        logic fixed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // deque model state
    logic [WORD_W-1:0] ring_words [DEPTH];
    logic [COUNT_W-1:0] top_pos = '0;
    logic [COUNT_W-1:0] bot_pos = '0;

    rsp_t pending_rsp [$];
    dir_row_t dir_tab [$];
    rsp_t want_rsp;

    logic quiet = 1'b0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int n_stored = 0;
    int n_taken = 0;
    int n_full = 0;
    int n_null = 0;
    int n_empty = 0;
    int n_sent = 0;

    work_stealing_deque #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic deque_apply(input req_t op, output rsp_t res);
        logic [COUNT_W-1:0] held;
        held = bot_pos - top_pos;
        res = '0;
        res.status = ST_DONE;
        case (op.cmd)
            CMD_PUSH:
            begin
                if (op.work_word == '0)
                    res.status = ST_NULL;
                else if (held >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    ring_words[bot_pos % DEPTH] = op.work_word;
                    bot_pos = bot_pos + 1'b1;
                end
            end
            CMD_POP:
            begin
                if (held == '0)
                    res.status = ST_EMPTY;
                else
                begin
                    bot_pos = bot_pos - 1'b1;
                    res.taken_word = ring_words[bot_pos % DEPTH];
                end
            end
            CMD_STEAL:
            begin
                if (held == '0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.taken_word = ring_words[top_pos % DEPTH];
                    top_pos = top_pos + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        // indices wrap at twice the depth, which is the 5-bit wrap here
        res.count = bot_pos - top_pos;
    endtask

    task automatic add_row(input logic [1:0] cmd, input logic [WORD_W-1:0] word,
                           input logic fixed, input logic [1:0] st,
                           input logic [WORD_W-1:0] taken, input logic [COUNT_W-1:0] cnt);
        dir_row_t row;
        row.op.cmd = cmd;
        row.op.work_word = word;
        row.fixed = fixed;
        row.want.status = st;
        row.want.taken_word = taken;
        row.want.count = cnt;
        dir_tab.push_back(row);
    endtask

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_req(input req_t op, input logic fixed, input rsp_t want);
        rsp_t res;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= op;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        deque_apply(op, res);
        if (fixed)
            res = want;
        pending_rsp.push_back(res);
        n_sent++;
        case (res.status)
            ST_FULL:  n_full++;
            ST_NULL:  n_null++;
            ST_EMPTY: n_empty++;
            default:
            begin
                if (op.cmd == CMD_PUSH)
                    n_stored++;
                else if (op.cmd != CMD_NONE)
                    n_taken++;
            end
        endcase
        @(negedge clk);
    endtask

    function automatic req_t rand_req(input int push_pct);
        req_t op;
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct)
            op.cmd = CMD_PUSH;
        else if (roll < 96)
            op.cmd = ($urandom_range(1) == 1) ? CMD_POP : CMD_STEAL;
        else
            op.cmd = CMD_NONE;
        case ($urandom_range(19))
            0:       op.work_word = '0;
            1:       op.work_word = ALL_ONES;
            2:       op.work_word = 64'd1;
            3:       op.work_word = TOP_BIT;
            default: op.work_word = {$urandom, $urandom};
        endcase
        return op;
    endfunction

    task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
        begin
            $write("mismatch (%s): expected status %0d taken %h count %0d",
                   what, want.status, want.taken_word, want.count);
            $display(", got status %0d taken %h count %0d",
                     got.status, got.taken_word, got.count);
        end
    endtask

    initial
    begin : stimulus
        int push_pct;
        push_pct = 50;

        add_row(CMD_POP,   '0,       1'b1, ST_EMPTY, '0, 5'd0);
        add_row(CMD_STEAL, ALL_ONES, 1'b1, ST_EMPTY, '0, 5'd0);
        add_row(CMD_NONE,  ALL_ONES, 1'b1, ST_DONE,  '0, 5'd0);
        add_row(CMD_PUSH,  '0,       1'b1, ST_NULL,  '0, 5'd0);
        add_row(CMD_PUSH,  ALL_ONES, 1'b1, ST_DONE,  '0, 5'd1);
        add_row(CMD_PUSH,  64'd1,    1'b1, ST_DONE,  '0, 5'd2);
        add_row(CMD_POP,   '0,       1'b1, ST_DONE,  64'd1, 5'd1);
        add_row(CMD_STEAL, '0,       1'b1, ST_DONE,  ALL_ONES, 5'd0);
        // fill to capacity, then a refused push and a null push while full
        for (int k = 0; k < DEPTH; k++)
            add_row(CMD_PUSH, {$urandom, $urandom} | 64'd1, 1'b0, ST_DONE, '0, '0);
        add_row(CMD_PUSH,  TOP_BIT,  1'b1, ST_FULL,  '0, COUNT_W'(DEPTH));
        add_row(CMD_PUSH,  '0,       1'b1, ST_NULL,  '0, COUNT_W'(DEPTH));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < dir_tab.size(); i++)
            send_req(dir_tab[i].op, dir_tab[i].fixed, dir_tab[i].want);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // bursts lean toward filling or draining so both ends get hit
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       push_pct = 75;
                    1:       push_pct = 30;
                    default: push_pct = 50;
                endcase
            end
            quiet = (i >= 800 && i < 1100);
            if (i == 300)
                hold_go = 1'b1;
            send_req(rand_req(push_pct), 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d requests: %0d stored, %0d taken by pop or steal",
                 n_sent, n_stored, n_taken);
        $display("refusals: %0d full, %0d null, %0d empty; %0d mismatches",
                 n_full, n_null, n_empty, fail_count);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // response side ready, with one long hold-off while requests keep coming
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (quiet)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                note_mismatch("no result pending", '0, rsp);
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (rsp.status !== want_rsp.status || rsp.taken_word !== want_rsp.taken_word
                    || rsp.count !== want_rsp.count)
                    note_mismatch("field", want_rsp, rsp);
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule : work_stealing_deque_tb

`default_nettype wire

// File: work_stealing_deque.f
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_mem.sv
hw/rtl/wsd_ctrl.sv
hw/rtl/work_stealing_deque.sv
sim/work_stealing_deque_tb.sv
